// ----- sv/rfc_pkg.sv -----
package rfc_pkg;

   localparam int MAX_FRAME = 256;
   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int FIRST_PAYLOAD_POS = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_COMMAND    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_REQUEST_ID = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MINIMUM_LENGTH      = 2'd2;

   localparam logic [7:0]  RESET_EXPECTED_COMMAND    = 8'hA0;
   localparam logic [15:0] RESET_EXPECTED_REQUEST_ID = 16'h0000;
   localparam logic [7:0]  RESET_MINIMUM_LENGTH      = 8'd7;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT    = 3'd1;
   localparam logic [2:0] STATUS_CRC_ERROR    = 3'd2;
   localparam logic [2:0] STATUS_CMD_MISMATCH = 3'd3;
   localparam logic [2:0] STATUS_ID_MISMATCH  = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef struct packed {
      logic [7:0]  expected_command;
      logic [15:0] expected_request_id;
      logic [7:0]  minimum_length;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [7:0]  sender_address;
      logic [15:0] word_value;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic        has_payload;
      logic [7:0]  payload_byte;
      logic        has_status;
      logic [2:0]  status;
      logic [7:0]  sender_address;
      logic [15:0] word_value;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- sv/rfc_if.sv -----
interface rfc_req_if
   import rfc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rfc_rsp_if
   import rfc_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [7:0]  sender_address;
   logic [15:0] word_value;
   logic        last_result;

   modport source (output valid, output item_kind, output payload_byte, output status,
                   output sender_address, output word_value, output last_result,
                   input ready);
   modport sink (input valid, input item_kind, input payload_byte, input status,
                 input sender_address, input word_value, input last_result,
                 output ready);
endinterface

interface rfc_csr_if
   import rfc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/rfc_front.sv -----
module rfc_front
   import rfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   output logic       push,
   output entry_type  push_entry,
   input  queue_status_type queue_status
);

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       delay0_ff, delay1_ff;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      reqid_ff, reqid_in;
   logic [15:0]      word_ff, word_in;
   logic             accept;
   logic             has_payload;
   logic [2:0]       status;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   assign in_ready = !queue_status.full;
   assign accept = in_valid && in_ready;

   always_comb begin
      crc_in = crc_update(crc_ff, rx_byte);
      addr_in = addr_ff;
      cmd_in = cmd_ff;
      reqid_in = reqid_ff;
      word_in = word_ff;
      if (pos_ff == POS_W'(0)) begin
         addr_in = rx_byte;
      end
      if (pos_ff == POS_W'(1)) begin
         cmd_in = rx_byte;
      end
      if (pos_ff == POS_W'(2)) begin
         reqid_in = {rx_byte, reqid_ff[7:0]};
      end
      if (pos_ff == POS_W'(3)) begin
         reqid_in = {reqid_ff[15:8], rx_byte};
      end
      if (pos_ff == POS_W'(4)) begin
         word_in = {rx_byte, word_ff[7:0]};
      end
      if (pos_ff == POS_W'(5)) begin
         word_in = {word_ff[15:8], rx_byte};
      end
      if (pos_ff < POS_W'(MAX_FRAME)) begin
         pos_in = pos_ff + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end
      has_payload = (pos_ff >= POS_W'(FIRST_PAYLOAD_POS));

      priority if (pos_in < POS_W'(cfg.minimum_length)) begin
         status = STATUS_TOO_SHORT;
      end else if (crc_in != 16'h0000) begin
         status = STATUS_CRC_ERROR;
      end else if (cmd_in != cfg.expected_command) begin
         status = STATUS_CMD_MISMATCH;
      end else if (reqid_in != cfg.expected_request_id) begin
         status = STATUS_ID_MISMATCH;
      end else begin
         status = STATUS_OK;
      end

      push = accept && (has_payload || frame_end);
      push_entry.has_payload = has_payload;
      push_entry.payload_byte = delay1_ff;
      push_entry.has_status = frame_end;
      push_entry.status = status;
      push_entry.sender_address = addr_in;
      push_entry.word_value = word_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && frame_end)) begin
         crc_ff <= CRC_INIT;
         pos_ff <= '0;
         delay0_ff <= '0;
         delay1_ff <= '0;
         addr_ff <= '0;
         cmd_ff <= '0;
         reqid_ff <= '0;
         word_ff <= '0;
      end else if (accept) begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         delay0_ff <= rx_byte;
         delay1_ff <= delay0_ff;
         addr_ff <= addr_in;
         cmd_ff <= cmd_in;
         reqid_ff <= reqid_in;
         word_ff <= word_in;
      end
   end

endmodule

// ----- sv/rfc_queue.sv -----
module rfc_queue
   import rfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type queue_status
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign queue_status.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

// ----- sv/rfc_back.sv -----
module rfc_back
   import rfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head_entry,
   input  queue_status_type queue_status,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output result_type       out_word
);

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type pend_ff, pend_in;
   result_type payload_word, status_word;
   logic       load;

   always_comb begin
      payload_word = '0;
      payload_word.item_kind = KIND_PAYLOAD;
      payload_word.payload_byte = head_entry.payload_byte;

      status_word = '0;
      status_word.item_kind = KIND_STATUS;
      status_word.status = head_entry.status;
      status_word.sender_address = head_entry.sender_address;
      status_word.word_value = head_entry.word_value;
      status_word.last_result = 1'b1;

      load = !out_valid_ff || out_ready;
      pop = load && !pend_valid_ff && !queue_status.empty;

      out_valid_in = out_valid_ff && !out_ready;
      out_in = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      if (load && pend_valid_ff) begin
         out_valid_in = 1'b1;
         out_in = pend_ff;
         pend_valid_in = 1'b0;
      end else if (pop) begin
         out_valid_in = 1'b1;
         if (head_entry.has_payload) begin
            out_in = payload_word;
            pend_valid_in = head_entry.has_status;
            pend_in = status_word;
         end else begin
            out_in = status_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      pend_ff <= pend_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word = out_ff;

endmodule

// ----- sv/rtu_response_frame_checker_unit.sv -----
// Checks received response frames, one byte per word on the request channel, with
// frame_end set on the last byte. The CRC-16 runs over every byte including the
// trailing CRC pair, and the frame passes when the residue is zero, the length reaches
// the configured minimum, and the command and request id match the configured values.
// The response channel carries payload words (bytes 4 to n-3, each delayed by two
// bytes) and one status word per frame with the sender address and the word from
// bytes 4 and 5. The status word ends the frame and tells whether to keep the payload.
// One byte is accepted per cycle while the queue has room. A result word is queued
// with the byte that causes it; the last byte of a frame that carries payload yields
// two words, the status word held back until the payload word leaves the output stage.
// A four-entry queue sits between the byte checker and the output stage, so bytes
// keep flowing while the receiver stalls until the queue fills; then req ready drops.
// The configuration channel is always ready and should be written only while idle.
// Reset clears the frame state, the queue and the output stage, and loads the
// register reset values; no clearing pass is needed.
module rtu_response_frame_checker_unit
   import rfc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   rfc_req_if.sink   req_chan,
   rfc_rsp_if.source rsp_chan,
   rfc_csr_if.sink   csr_chan
);

   cfg_type          cfg_ff;
   logic             push;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             pop;
   queue_status_type queue_status;
   result_type       out_word;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= RESET_EXPECTED_COMMAND;
         cfg_ff.expected_request_id <= RESET_EXPECTED_REQUEST_ID;
         cfg_ff.minimum_length <= RESET_MINIMUM_LENGTH;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_EXPECTED_COMMAND: begin
               cfg_ff.expected_command <= csr_chan.data[7:0];
            end
            REG_EXPECTED_REQUEST_ID: begin
               cfg_ff.expected_request_id <= csr_chan.data;
            end
            REG_MINIMUM_LENGTH: begin
               cfg_ff.minimum_length <= csr_chan.data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   rfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .rx_byte      (req_chan.rx_byte),
      .frame_end    (req_chan.frame_end),
      .push         (push),
      .push_entry   (push_entry),
      .queue_status (queue_status)
   );

   rfc_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .head_entry   (head_entry),
      .queue_status (queue_status)
   );

   rfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_word     (out_word)
   );

   assign rsp_chan.item_kind = out_word.item_kind;
   assign rsp_chan.payload_byte = out_word.payload_byte;
   assign rsp_chan.status = out_word.status;
   assign rsp_chan.sender_address = out_word.sender_address;
   assign rsp_chan.word_value = out_word.word_value;
   assign rsp_chan.last_result = out_word.last_result;

endmodule

// ----- sv/rfc_checker.sv -----
module rfc_checker
   import rfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_item_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_sender_address,
   input logic [15:0] rsp_word_value,
   input logic        rsp_last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_result == (rsp_item_kind == KIND_STATUS)))
      else $error("last marker does not match word kind");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_PAYLOAD |->
         rsp_status == STATUS_OK && rsp_sender_address == 8'h00 && rsp_word_value == 16'h0000)
      else $error("payload word carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_STATUS |-> rsp_payload_byte == 8'h00)
      else $error("status word carries a payload byte");

endmodule

bind rtu_response_frame_checker_unit rfc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_item_kind      (rsp_chan.item_kind),
   .rsp_payload_byte   (rsp_chan.payload_byte),
   .rsp_status         (rsp_chan.status),
   .rsp_sender_address (rsp_chan.sender_address),
   .rsp_word_value     (rsp_chan.word_value),
   .rsp_last_result    (rsp_chan.last_result)
);

// ----- verif/rfc_frame_monitor.sv -----
module rfc_frame_monitor
   import rfc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rfc_req_if   req_mon,
   rfc_rsp_if   rsp_mon,
   rfc_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   cfg_type     cfg;
   logic [15:0] crc_acc;
   int unsigned position;
   logic [7:0]  lag [2];
   logic [7:0]  addr_seen;
   logic [7:0]  cmd_seen;
   logic [15:0] id_seen;
   logic [15:0] word_seen;
   result_type  expected_words [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s, got 0x%0h, wanted 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic clear_frame();
      crc_acc = CRC_INIT;
      position = 0;
      lag[0] = 8'h00;
      lag[1] = 8'h00;
      addr_seen = 8'h00;
      cmd_seen = 8'h00;
      id_seen = 16'h0000;
      word_seen = 16'h0000;
   endtask

   task automatic predict_byte(logic [7:0] b, logic last);
      result_type w;
      crc_acc = crc_after_byte(crc_acc, b);
      case (position)
         0: addr_seen = b;
         1: cmd_seen = b;
         2: id_seen[15:8] = b;
         3: id_seen[7:0] = b;
         4: word_seen[15:8] = b;
         5: word_seen[7:0] = b;
         default: ;
      endcase
      // Payload leaves two bytes late, so the trailing CRC pair is never emitted.
      if (position >= FIRST_PAYLOAD_POS) begin
         w = '0;
         w.item_kind = KIND_PAYLOAD;
         w.payload_byte = lag[1];
         expected_words = {expected_words, w};
      end
      lag[1] = lag[0];
      lag[0] = b;
      if (position < MAX_FRAME) position++;
      if (last) begin
         w = '0;
         w.item_kind = KIND_STATUS;
         if (position < cfg.minimum_length) w.status = STATUS_TOO_SHORT;
         else if (crc_acc != 16'h0000) w.status = STATUS_CRC_ERROR;
         else if (cmd_seen != cfg.expected_command) w.status = STATUS_CMD_MISMATCH;
         else if (id_seen != cfg.expected_request_id) w.status = STATUS_ID_MISMATCH;
         else w.status = STATUS_OK;
         w.sender_address = addr_seen;
         w.word_value = word_seen;
         w.last_result = 1'b1;
         expected_words = {expected_words, w};
         clear_frame();
      end
   endtask

   task automatic check_word();
      result_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected, item_kind", rsp_mon.item_kind, 0);
         return;
      end
      want = expected_words.pop_front();
      if (rsp_mon.item_kind !== want.item_kind)
         report_mismatch("item_kind", rsp_mon.item_kind, want.item_kind);
      if (rsp_mon.payload_byte !== want.payload_byte)
         report_mismatch("payload_byte", rsp_mon.payload_byte, want.payload_byte);
      if (rsp_mon.status !== want.status)
         report_mismatch("status", rsp_mon.status, want.status);
      if (rsp_mon.sender_address !== want.sender_address)
         report_mismatch("sender_address", rsp_mon.sender_address, want.sender_address);
      if (rsp_mon.word_value !== want.word_value)
         report_mismatch("word_value", rsp_mon.word_value, want.word_value);
      if (rsp_mon.last_result !== want.last_result)
         report_mismatch("last_result", rsp_mon.last_result, want.last_result);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.expected_command = RESET_EXPECTED_COMMAND;
         cfg.expected_request_id = RESET_EXPECTED_REQUEST_ID;
         cfg.minimum_length = RESET_MINIMUM_LENGTH;
         clear_frame();
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_word();
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_EXPECTED_COMMAND:    cfg.expected_command = csr_mon.data[7:0];
               REG_EXPECTED_REQUEST_ID: cfg.expected_request_id = csr_mon.data;
               REG_MINIMUM_LENGTH:      cfg.minimum_length = csr_mon.data[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_byte(req_mon.rx_byte, req_mon.frame_end);
      end
      pending = expected_words.size();
   end

endmodule

// ----- verif/tb_rtu_response_frame_checker_unit.sv -----
module tb_rtu_response_frame_checker_unit;
   import rfc_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   bit   hold_request = 1'b0;
   int   bytes_sent = 0;

   logic [7:0]  cur_cmd;
   logic [15:0] cur_id;
   logic [7:0]  frame_bytes [$];

   rfc_req_if req_chan ();
   rfc_rsp_if rsp_chan ();
   rfc_csr_if csr_chan ();

   rtu_response_frame_checker_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rfc_frame_monitor monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // The receiver stalls at random; a hold request makes it refuse words for a long stretch.
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 400;
            run_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_chan.ready <= 1'b1;
         end else begin
            run_left = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 120)
                                                    : $urandom_range(0, 6);
            stall_left = pick_gap();
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic last, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      req_chan.frame_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic drain_then_idle();
      pause_until_drained();
      repeat (8) @(posedge clock);
   endtask

   task automatic load_config(logic [7:0] cmd, logic [15:0] id, logic [7:0] min_len);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= REG_EXPECTED_COMMAND;
      csr_chan.data <= {8'h00, cmd};
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.index <= REG_EXPECTED_REQUEST_ID;
      csr_chan.data <= id;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.index <= REG_MINIMUM_LENGTH;
      csr_chan.data <= {8'h00, min_len};
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      cur_cmd = cmd;
      cur_id = id;
   endtask

   task automatic add_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endtask

   task automatic start_frame(logic [7:0] addr, logic [7:0] cmd, logic [15:0] id);
      frame_bytes.delete();
      add_byte(addr);
      add_byte(cmd);
      add_byte(id[15:8]);
      add_byte(id[7:0]);
   endtask

   task automatic seal_frame();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = crc16_next(c, frame_bytes[i]);
      add_byte(c[7:0]);
      add_byte(c[15:8]);
   endtask

   // A roll of zero with a length of six or more gives the current command and request id and a correct CRC.
   task automatic build_frame(int len, int roll);
      logic [7:0]  cmd;
      logic [15:0] id;
      frame_bytes.delete();
      if (roll >= 90 || len < 2) begin
         repeat (len) add_byte(8'($urandom));
      end else if (len < 6) begin
         repeat (len - 2) add_byte(8'($urandom));
         seal_frame();
      end else begin
         cmd = cur_cmd;
         id = cur_id;
         if (roll >= 80) begin
            id = id ^ 16'($urandom_range(1, 65535));
         end else if (roll >= 70) begin
            cmd = cmd ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1) id = 16'($urandom);
         end
         start_frame(8'($urandom), cmd, id);
         repeat (len - 6) add_byte(8'($urandom));
         seal_frame();
         if (roll >= 55 && roll < 70)
            frame_bytes[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
   endtask

   task automatic send_frame(bit steady, int pause_at);
      int gap;
      foreach (frame_bytes[i]) begin
         gap = steady ? 0 : pick_gap();
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, gap);
         if (i == pause_at || (!steady && $urandom_range(0, 99) < 2)) pause_until_drained();
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom_range(1, 5);
      if (r < 80) return $urandom_range(6, 16);
      if (r < 96) return $urandom_range(17, 40);
      return $urandom_range(41, 90);
   endfunction

   task automatic run_phase(int target);
      int phase_start;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < target) begin
         build_frame(pick_length(), $urandom_range(0, 99));
         send_frame($urandom_range(0, 99) < 20, -1);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      req_chan.frame_end <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_EXPECTED_COMMAND;
      csr_chan.data <= 16'h0000;
      cur_cmd = RESET_EXPECTED_COMMAND;
      cur_id = RESET_EXPECTED_REQUEST_ID;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A one-byte frame, then a six-byte frame whose word is its own CRC pair.
      build_frame(1, 99);
      frame_bytes[0] = 8'hFF;
      send_frame(1'b0, -1);
      build_frame(6, 0);
      send_frame(1'b0, -1);
      start_frame(8'h00, cur_cmd, cur_id);
      add_byte(8'hFF);
      add_byte(8'h00);
      seal_frame();
      send_frame(1'b1, -1);
      start_frame(8'hFF, 8'hFF, cur_id);
      add_byte(8'h5A);
      seal_frame();
      send_frame(1'b0, -1);
      start_frame(8'h81, cur_cmd, 16'hFFFF);
      add_byte(8'hA5);
      seal_frame();
      send_frame(1'b0, -1);
      run_phase(130);

      drain_then_idle();
      load_config(8'h00, 16'hFFFF, 8'd6);
      build_frame(40, 0);
      hold_request = 1'b1;
      send_frame(1'b1, 20);
      run_phase(130);

      drain_then_idle();
      load_config(8'hFF, 16'($urandom), 8'd0);
      run_phase(130);

      drain_then_idle();
      load_config(8'($urandom), 16'($urandom), 8'd1);
      run_phase(130);

      drain_then_idle();
      load_config(8'($urandom), 16'($urandom), 8'd255);
      build_frame(255, 0);
      send_frame(1'b0, -1);
      build_frame(270, 0);
      send_frame(1'b0, -1);
      run_phase(60);

      drain_then_idle();
      load_config(8'($urandom), 16'($urandom), 8'($urandom_range(6, 20)));
      run_phase(130);

      drain_then_idle();
      load_config(RESET_EXPECTED_COMMAND, RESET_EXPECTED_REQUEST_ID, RESET_MINIMUM_LENGTH);
      run_phase(100);

      pause_until_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/rfc_pkg.sv
sv/rfc_if.sv
sv/rfc_front.sv
sv/rfc_queue.sv
sv/rfc_back.sv
sv/rtu_response_frame_checker_unit.sv
sv/rfc_checker.sv
verif/rfc_frame_monitor.sv
verif/tb_rtu_response_frame_checker_unit.sv
